// File: rtl/core/ring_neighbor_arbiter_aging_unit_defines.svh
// Assertion macros for the ring neighbour arbiter.
// Used by the top level only; needs nothing else.
`ifndef RING_NEIGHBOR_ARBITER_AGING_UNIT_DEFINES_SVH
`define RING_NEIGHBOR_ARBITER_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RNAA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnaa: implication failed");

// Next-cycle implication, disabled while reset is high.
`define RNAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnaa: next-cycle implication failed");

`endif

// File: rtl/core/rnaa_pkg.sv
// Shared constants, types and ring helpers of the ring neighbour arbiter.
// No dependencies.
`default_nettype none

package rnaa_pkg;

   localparam int SEATS   = 5;
   localparam int SEAT_W  = 3;
   localparam int TIME_W  = 48;
   localparam int TOTAL_W = 64;
   localparam int MODE_W  = 2;

   localparam logic [TIME_W-1:0] THRESH_RESET = TIME_W'(1000000);

   localparam logic [MODE_W-1:0] MODE_THINKING = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EATING   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HUNGRY   = 2'd2;

   localparam logic FUNC_REQUEST = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef logic [SEATS-1:0][MODE_W-1:0]  mode_vec_type;
   typedef logic [SEATS-1:0][TIME_W-1:0]  time_vec_type;
   typedef logic [SEATS-1:0][TOTAL_W-1:0] total_vec_type;

   // Event after the wait lanes: waits and comparison flags per seat.
   typedef struct packed {
      logic                   func;
      logic [SEATS-1:0]       sel;
      logic [TIME_W-1:0]      now;
      time_vec_type           waits;
      logic [SEATS-1:0]       over_thr;
      logic [SEATS-1:0]       left_longer;
      logic [SEATS-1:0]       right_longer;
   } event_type;

   typedef struct packed {
      logic [SEAT_W-1:0]  granted_seat;
      logic [TIME_W-1:0]  wait_time;
      logic [TOTAL_W-1:0] total_wait;
      logic               last;
   } rsp_word_type;

   // Up to two words pushed at once; first word sits in w0.
   typedef struct packed {
      logic [1:0]   n;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } queue_status_type;

   function automatic int left_of(input int i);
      return (i + SEATS - 1) % SEATS;
   endfunction

   function automatic int right_of(input int i);
      return (i + 1) % SEATS;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/rnaa_wait_stage.sv
// Input register and per-seat wait lanes of the ring neighbour arbiter.
// Depends on rnaa_pkg.
`default_nettype none

module rnaa_wait_stage
   import rnaa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [SEAT_W-1:0]   req_seat,
   input  wire logic [TIME_W-1:0]   req_now,
   input  wire logic [TIME_W-1:0]   thresh,
   input  wire time_vec_type        start_next,
   input  wire logic                y_free,
   output logic                     x_valid,
   output event_type                x_event
);

   logic              valid_ff, valid_in;
   logic              func_ff;
   logic [SEAT_W-1:0] seat_ff;
   logic [TIME_W-1:0] now_ff;
   logic              accept;

   assign req_stall = valid_ff && !y_free;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept ? 1'b1 : (y_free ? 1'b0 : valid_ff);
   assign x_valid   = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         func_ff <= req_func;
         seat_ff <= req_seat;
         now_ff  <= req_now;
      end
   end

   // One subtractor per seat; the requesting seat restarts at zero.
   always_comb begin
      x_event.func = func_ff;
      x_event.now  = now_ff;
      for (int i = 0; i < SEATS; i++) begin
         x_event.sel[i] = (seat_ff == SEAT_W'(i));
         if (now_ff >= start_next[i]) begin
            x_event.waits[i] = now_ff - start_next[i];
         end else begin
            x_event.waits[i] = '0;
         end
         if (func_ff == FUNC_REQUEST && x_event.sel[i]) begin
            x_event.waits[i] = '0;
         end
      end
      for (int i = 0; i < SEATS; i++) begin
         x_event.over_thr[i]     = x_event.waits[i] > thresh;
         x_event.left_longer[i]  = x_event.waits[left_of(i)] > x_event.waits[i];
         x_event.right_longer[i] = x_event.waits[right_of(i)] > x_event.waits[i];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rnaa_grant_stage.sv
// Seat state and grant decision of the ring neighbour arbiter.
// Depends on rnaa_pkg.
`default_nettype none

module rnaa_grant_stage
   import rnaa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             x_valid,
   input  wire event_type        x_event,
   input  wire queue_status_type q_stat,
   output logic                  y_free,
   output time_vec_type          start_next,
   output push_type              push
);

   logic          valid_ff, valid_in;
   event_type     ev_ff;
   mode_vec_type  mode_ff, mode_in;
   time_vec_type  start_ff;
   total_vec_type total_ff, total_in;
   total_vec_type sums;

   logic             fire, ev_ok, is_req;
   logic [2:0]       need, room_used;
   logic [SEATS-1:0] cand1, cand2, g1, g2, cand_l, cand_r;
   mode_vec_type     m0, m1;
   rsp_word_type     wd1, wd2;

   function automatic logic [SEATS-1:0] lanes_ok(input mode_vec_type m,
                                                 input event_type e);
      logic [SEATS-1:0] ok;
      int l, r;
      for (int i = 0; i < SEATS; i++) begin
         l = left_of(i);
         r = right_of(i);
         ok[i] = (m[i] == MODE_HUNGRY) && (m[l] != MODE_EATING) && (m[r] != MODE_EATING)
            && !((m[l] == MODE_HUNGRY) && e.left_longer[i] && e.over_thr[l])
            && !((m[r] == MODE_HUNGRY) && e.right_longer[i] && e.over_thr[r]);
      end
      return ok;
   endfunction

   function automatic rsp_word_type make_word(input logic [SEATS-1:0] g,
                                              input event_type e,
                                              input total_vec_type s);
      rsp_word_type wd;
      wd = '0;
      for (int i = 0; i < SEATS; i++) begin
         if (g[i]) begin
            wd.granted_seat = wd.granted_seat | SEAT_W'(i);
            wd.wait_time    = wd.wait_time | e.waits[i];
            wd.total_wait   = wd.total_wait | s[i];
         end
      end
      return wd;
   endfunction

   // A release may push two words, a request one; reserve that much room.
   assign need      = (ev_ff.func == FUNC_RELEASE) ? 3'd2 : 3'd1;
   assign room_used = {1'b0, q_stat.count} - {2'b00, q_stat.pop} + need;
   assign fire      = valid_ff && (room_used <= 3'd2);
   assign y_free    = !valid_ff || fire;
   assign valid_in  = (x_valid && y_free) ? 1'b1 : (fire ? 1'b0 : valid_ff);
   assign is_req    = (ev_ff.func == FUNC_REQUEST);

   always_comb begin
      ev_ok = 1'b0;
      for (int i = 0; i < SEATS; i++) begin
         if (ev_ff.sel[i]) begin
            ev_ok = is_req ? (mode_ff[i] == MODE_THINKING) : (mode_ff[i] == MODE_EATING);
         end
         cand_l[i] = ev_ff.sel[right_of(i)];
         cand_r[i] = ev_ff.sel[left_of(i)];
         sums[i] = TOTAL_W'({1'b0, total_ff[i]} + (TOTAL_W + 1)'(ev_ff.waits[i]));
         if (({1'b0, total_ff[i]} + (TOTAL_W + 1)'(ev_ff.waits[i])) >> TOTAL_W != '0) begin
            sums[i] = '1;
         end
      end

      m0 = mode_ff;
      for (int i = 0; i < SEATS; i++) begin
         if (ev_ok && ev_ff.sel[i]) begin
            m0[i] = is_req ? MODE_HUNGRY : MODE_THINKING;
         end
      end

      // Left neighbour first; the right check sees its outcome.
      cand1 = !ev_ok ? '0 : (is_req ? ev_ff.sel : cand_l);
      cand2 = (ev_ok && !is_req) ? cand_r : '0;
      g1 = lanes_ok(m0, ev_ff) & cand1;
      m1 = m0;
      for (int i = 0; i < SEATS; i++) begin
         if (g1[i]) begin
            m1[i] = MODE_EATING;
         end
      end
      g2 = lanes_ok(m1, ev_ff) & cand2;
      mode_in = m1;
      for (int i = 0; i < SEATS; i++) begin
         if (g2[i]) begin
            mode_in[i] = MODE_EATING;
         end
      end

      total_in   = total_ff;
      start_next = start_ff;
      for (int i = 0; i < SEATS; i++) begin
         if (fire && (g1[i] || g2[i])) begin
            total_in[i] = sums[i];
         end
         if (fire && ev_ok && is_req && ev_ff.sel[i]) begin
            start_next[i] = ev_ff.now;
         end
      end

      wd1 = make_word(g1, ev_ff, sums);
      wd2 = make_word(g2, ev_ff, sums);
      wd2.last = 1'b1;
      push.w1 = wd2;
      if (|g1) begin
         push.w0 = wd1;
         push.w0.last = !(|g2);
      end else begin
         push.w0 = wd2;
      end
      push.n = fire ? ({1'b0, |g1} + {1'b0, |g2}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff  <= '0;
         start_ff <= '0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            mode_ff <= mode_in;
         end
         start_ff <= start_next;
         total_ff <= total_in;
      end
      if (x_valid && y_free) begin
         ev_ff <= x_event;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rnaa_rsp_queue.sv
// Two-slot result queue of the ring neighbour arbiter.
// Depends on rnaa_pkg.
`default_nettype none

module rnaa_rsp_queue
   import rnaa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire push_type             push,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output rsp_word_type              rsp_word,
   output queue_status_type          q_stat
);

   logic [1:0]   count_ff, count_in, kept;
   rsp_word_type slot0_ff, slot0_in, slot1_ff, slot1_in, head_kept;
   logic         pop;

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_word     = slot0_ff;
   assign pop          = rsp_valid && !rsp_stall;
   assign q_stat.count = count_ff;
   assign q_stat.pop   = pop;

   // Drop the head on a pop, then append the pushed words behind what stays.
   always_comb begin
      kept      = count_ff - {1'b0, pop};
      head_kept = pop ? slot1_ff : slot0_ff;
      count_in  = kept + push.n;
      unique case (kept)
         2'd0: begin
            slot0_in = push.w0;
            slot1_in = push.w1;
         end
         2'd1: begin
            slot0_in = head_kept;
            slot1_in = push.w0;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/ring_neighbor_arbiter_aging_unit.sv
// Top level of the ring neighbour arbiter with aging.
// Depends on rnaa_pkg, rnaa_wait_stage, rnaa_grant_stage, rnaa_rsp_queue and the defines header.
`default_nettype none

// Arbiter for SEATS seats in a ring, each sharing a resource with both
// neighbours. A request word (func 0) makes a thinking seat hungry, stamps
// req_now and tries to grant it; a release word (func 1) makes an eating seat
// think and tries its left, then its right neighbour. A hungry seat is granted
// when neither neighbour eats and no hungry neighbour has waited both longer
// than it and longer than csr_starve_threshold. Each grant yields one result
// word with the wait and the saturating per-seat total; rsp_last marks the
// final word of an event, and events that change nothing yield no word.
// Timing: an accepted word passes the input register and the grant register,
// whose result words are written into a two-slot result queue. A new word is
// taken every cycle while results drain; a release that grants both
// neighbours puts two words on the result port one after the other, so a run
// of such releases stalls the input while they drain. The per-seat wait
// subtractors and comparisons sit in the first stage, the grant choice and
// total update in the second. Write the threshold only while the block is idle.
module ring_neighbor_arbiter_aging_unit
   import rnaa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [SEAT_W-1:0]   req_seat,
   input  wire logic [TIME_W-1:0]   req_now,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SEAT_W-1:0]        rsp_granted_seat,
   output logic [TIME_W-1:0]        rsp_wait_time,
   output logic [TOTAL_W-1:0]       rsp_total_wait,
   output logic                     rsp_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TIME_W-1:0]   csr_starve_threshold
);

`include "ring_neighbor_arbiter_aging_unit_defines.svh"

   logic [TIME_W-1:0] starve_ff;
   logic             x_valid, y_free;
   event_type        x_event;
   time_vec_type     start_next;
   push_type         push;
   queue_status_type q_stat;
   rsp_word_type     rsp_word;

   // Threshold register; always ready. The user must write it only when idle; the block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         starve_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         starve_ff <= csr_starve_threshold;
      end
   end

   // Stage one: hold the incoming word and compute every seat's wait.
   rnaa_wait_stage u_wait (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_seat   (req_seat),
      .req_now    (req_now),
      .thresh     (starve_ff),
      .start_next (start_next),
      .y_free     (y_free),
      .x_valid    (x_valid),
      .x_event    (x_event)
   );

   // Stage two: apply the event, decide up to two grants, update totals.
   rnaa_grant_stage u_grant (
      .clock      (clock),
      .reset      (reset),
      .x_valid    (x_valid),
      .x_event    (x_event),
      .q_stat     (q_stat),
      .y_free     (y_free),
      .start_next (start_next),
      .push       (push)
   );

   // Result queue: presents one word a cycle while rsp_stall is low; the second
   // word of a release waits in the back slot.
   rnaa_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .q_stat    (q_stat)
   );

   assign rsp_granted_seat = rsp_word.granted_seat;
   assign rsp_wait_time    = rsp_word.wait_time;
   assign rsp_total_wait   = rsp_word.total_wait;
   assign rsp_last         = rsp_word.last;

   // A non-final word always has its partner waiting behind it.
   `RNAA_ASSERT_IMP(a_pair_held, clock, reset, rsp_valid && !rsp_last, q_stat.count == 2'd2)
   // Taking a non-final word brings the final word of that event forward.
   `RNAA_ASSERT_NEXT(a_pair_next, clock, reset, rsp_valid && !rsp_last && !rsp_stall,
      rsp_valid && rsp_last)
   // Granted seats lie on the ring.
   `RNAA_ASSERT_IMP(a_seat_range, clock, reset, rsp_valid, rsp_granted_seat < SEAT_W'(SEATS))

endmodule

`default_nettype wire

// File: bench/tb_ring_neighbor_arbiter_aging_unit.sv
// Self-checking testbench for ring_neighbor_arbiter_aging_unit: directed and random
// seat events, grant words predicted by a local seat tracker and checked in order.
// Depends on rnaa_pkg and the arbiter RTL.
module tb_ring_neighbor_arbiter_aging_unit;
   import rnaa_pkg::*;

   localparam int PHASES          = 6;
   localparam int EVENTS_PER_PHASE = 238;
   localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake before giving up
   localparam int HOLD_CYCLES     = 300;   // long result back-pressure stretch
   localparam int SETTLE_CYCLES   = 4;     // margin for words still in the pipeline registers
   localparam int DRAIN_CYCLES    = 8;

   // Tracks every seat as the arbiter should see it and keeps the grant words
   // still owed by the block, oldest first.
   class seat_grant_tracker;
      logic [MODE_W-1:0]  seat_mode    [SEATS];
      logic [TIME_W-1:0]  hungry_since [SEATS];
      logic [TOTAL_W-1:0] waited_total [SEATS];
      logic [TIME_W-1:0]  threshold;
      rsp_word_type       grants_due[$];
      int                 errors;

      function new();
         threshold = THRESH_RESET;
         errors    = 0;
         for (int i = 0; i < SEATS; i++) begin
            seat_mode[i]    = MODE_THINKING;
            hungry_since[i] = '0;
            waited_total[i] = '0;
         end
      endfunction

      function void set_threshold(logic [TIME_W-1:0] value);
         threshold = value;
      endfunction

      // A clock running backwards against the stamp counts as no wait at all.
      function logic [TIME_W-1:0] hunger_age(int s, logic [TIME_W-1:0] now);
         return (now >= hungry_since[s]) ? now - hungry_since[s] : '0;
      endfunction

      function bit gives_way_to(int n, logic [TIME_W-1:0] own, logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] age;
         if (seat_mode[n] != MODE_HUNGRY) return 1'b0;
         age = hunger_age(n, now);
         return (age > own) && (age > threshold);
      endfunction

      function bit try_grant(int s, logic [TIME_W-1:0] now, output rsp_word_type word);
         int                 lft;
         int                 rgt;
         logic [TIME_W-1:0]  age;
         logic [TOTAL_W:0]   sum;
         lft  = (s + SEATS - 1) % SEATS;
         rgt  = (s + 1) % SEATS;
         word = '0;
         if (seat_mode[s] != MODE_HUNGRY) return 1'b0;
         if (seat_mode[lft] == MODE_EATING || seat_mode[rgt] == MODE_EATING) return 1'b0;
         age = hunger_age(s, now);
         if (gives_way_to(lft, age, now) || gives_way_to(rgt, age, now)) return 1'b0;
         seat_mode[s]    = MODE_EATING;
         sum             = {1'b0, waited_total[s]} + (TOTAL_W + 1)'(age);
         waited_total[s] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         word.granted_seat = SEAT_W'(s);
         word.wait_time    = age;
         word.total_wait   = waited_total[s];
         word.last         = 1'b0;
         return 1'b1;
      endfunction

      // Apply one accepted event word; returns 1 when it changed any seat.
      function bit note_event(logic func, logic [SEAT_W-1:0] seat, logic [TIME_W-1:0] now);
         int           s;
         int           due_before;
         rsp_word_type word;
         rsp_word_type tail;
         if (seat >= SEATS) return 1'b0;
         s          = int'(seat);
         due_before = grants_due.size();
         if (func == FUNC_REQUEST) begin
            if (seat_mode[s] != MODE_THINKING) return 1'b0;
            seat_mode[s]    = MODE_HUNGRY;
            hungry_since[s] = now;
            if (try_grant(s, now, word)) grants_due.push_back(word);
         end else begin
            if (seat_mode[s] != MODE_EATING) return 1'b0;
            seat_mode[s] = MODE_THINKING;
            // left neighbour first, then right
            if (try_grant((s + SEATS - 1) % SEATS, now, word)) grants_due.push_back(word);
            if (try_grant((s + 1) % SEATS, now, word)) grants_due.push_back(word);
         end
         if (grants_due.size() > due_before) begin
            tail      = grants_due.pop_back();
            tail.last = 1'b1;
            grants_due.push_back(tail);
         end
         return 1'b1;
      endfunction

      function void check_grant(rsp_word_type got);
         rsp_word_type want;
         if (grants_due.size() == 0) begin
            $error("grant word with none due: seat %0d wait %0d", got.granted_seat,
                   got.wait_time);
            errors++;
            return;
         end
         want = grants_due.pop_front();
         if (got.granted_seat !== want.granted_seat) begin
            $error("granted_seat: expected %0d, actual %0d", want.granted_seat,
                   got.granted_seat);
            errors++;
         end
         if (got.wait_time !== want.wait_time) begin
            $error("wait_time: expected %0d, actual %0d", want.wait_time, got.wait_time);
            errors++;
         end
         if (got.total_wait !== want.total_wait) begin
            $error("total_wait: expected %0d, actual %0d", want.total_wait, got.total_wait);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = FUNC_REQUEST;
   logic [SEAT_W-1:0]   req_seat = '0;
   logic [TIME_W-1:0]   req_now = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SEAT_W-1:0]   rsp_granted_seat;
   logic [TIME_W-1:0]   rsp_wait_time;
   logic [TOTAL_W-1:0]  rsp_total_wait;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TIME_W-1:0]   csr_starve_threshold = THRESH_RESET;

   seat_grant_tracker   tracker;
   int                  send_idle_pct = 31;
   int                  recv_idle_pct = 62;
   bit                  hold_request = 1'b0;
   logic [TIME_W-1:0]   ring_now = '0;   // running event clock for well-formed words

   ring_neighbor_arbiter_aging_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_seat             (req_seat),
      .req_now              (req_now),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_granted_seat     (rsp_granted_seat),
      .rsp_wait_time        (rsp_wait_time),
      .rsp_total_wait       (rsp_total_wait),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_starve_threshold (csr_starve_threshold)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Offer one event word, idling first at the current sender rate, and hold it
   // until the block takes it. The tracker is told at the accepting edge.
   task automatic send_event(input logic func, input logic [SEAT_W-1:0] seat,
                             input logic [TIME_W-1:0] now, output bit took);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_seat  <= seat;
      req_now   <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      took = tracker.note_event(func, seat, now);
   endtask

   // Drop valid, let every owed grant word drain, then allow for words still in
   // flight that produce nothing before touching the threshold.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.grants_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [TIME_W-1:0] value);
      csr_valid            <= 1'b1;
      csr_starve_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_threshold(value);
   endtask

   // Walk the ring through the corner cases under the reset threshold:
   // ignored words, a double grant on release, a seat giving way to an aged
   // neighbour, a clock that steps back and the longest possible wait.
   task automatic run_directed();
      bit took;
      send_event(FUNC_REQUEST, 3'd7, '1, took);            // seat beyond the ring
      send_event(FUNC_RELEASE, 3'd5, 48'd10, took);
      send_event(FUNC_REQUEST, 3'd6, 48'd10, took);
      send_event(FUNC_RELEASE, 3'd0, 48'd20, took);        // release while thinking
      send_event(FUNC_REQUEST, 3'd0, 48'd0, took);         // free ring, grant at once
      send_event(FUNC_REQUEST, 3'd0, 48'd50, took);        // request while eating
      send_event(FUNC_REQUEST, 3'd1, 48'd100, took);       // blocked by seat 0
      send_event(FUNC_REQUEST, 3'd1, 48'd150, took);       // request while hungry
      send_event(FUNC_REQUEST, 3'd4, 48'd200, took);       // blocked by seat 0
      send_event(FUNC_RELEASE, 3'd0, 48'd2000000, took);   // grants 4 then 1
      send_event(FUNC_RELEASE, 3'd1, 48'd2000100, took);
      send_event(FUNC_RELEASE, 3'd1, 48'd2000200, took);   // release while thinking
      send_event(FUNC_REQUEST, 3'd3, 48'd3000000, took);   // blocked by seat 4
      send_event(FUNC_REQUEST, 3'd2, 48'd5000000, took);   // gives way to aged seat 3
      send_event(FUNC_RELEASE, 3'd4, 48'd5100000, took);   // grants 3
      send_event(FUNC_RELEASE, 3'd3, 48'd5200000, took);   // grants 2
      send_event(FUNC_REQUEST, 3'd1, 48'd8000000, took);   // blocked by seat 2
      send_event(FUNC_RELEASE, 3'd2, 48'd7000000, took);   // clock behind the stamp
      send_event(FUNC_REQUEST, 3'd0, 48'd0, took);         // blocked by seat 1
      send_event(FUNC_RELEASE, 3'd1, '1, took);            // largest wait
      send_event(FUNC_REQUEST, 3'd3, '1, took);
      send_event(FUNC_RELEASE, 3'd0, '1, took);
      send_event(FUNC_RELEASE, 3'd3, '1, took);
   endtask

   // Mostly well-formed words (request a thinking seat, release an eating one)
   // on an advancing clock; the rest are random noise and backward steps.
   task automatic send_random(output bit took);
      int                pick;
      int                start;
      int                s;
      bit                found;
      logic              func;
      logic [SEAT_W-1:0] seat;
      logic [TIME_W-1:0] now;
      pick     = $urandom_range(99);
      ring_now = ring_now + TIME_W'($urandom_range(700000));
      now      = ring_now;
      func     = 1'($urandom_range(1));
      seat     = SEAT_W'($urandom_range(7));
      found    = 1'b0;
      if (pick < 6) begin
         now = {16'($urandom()), 32'($urandom())};
      end else if (pick >= 12) begin
         if (pick < 18) now = ring_now - TIME_W'($urandom_range(1500000));
         start = $urandom_range(SEATS - 1);
         for (int k = 0; k < SEATS; k++) begin
            s = (start + k) % SEATS;
            if (!found && tracker.seat_mode[s] == MODE_THINKING) begin
               func  = FUNC_REQUEST;
               seat  = SEAT_W'(s);
               found = 1'b1;
            end else if (!found && tracker.seat_mode[s] == MODE_EATING) begin
               func  = FUNC_RELEASE;
               seat  = SEAT_W'(s);
               found = 1'b1;
            end
         end
      end
      send_event(func, seat, now, took);
   endtask

   // Result side: check every accepted grant word, stall at the current rate
   // and, when asked, hold off for a long stretch so the block backs up.
   initial begin : result_side
      int           hold_left;
      bit           hold_done;
      rsp_word_type got;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.granted_seat = rsp_granted_seat;
            got.wait_time    = rsp_wait_time;
            got.total_wait   = rsp_total_wait;
            got.last         = rsp_last;
            tracker.check_grant(got);
         end
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Give up when no handshake of any kind has happened for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      bit                took;
      logic [TIME_W-1:0] phase_threshold;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         // walk the threshold through both extremes and a few ordinary settings
         case (ph)
            0:       phase_threshold = '0;
            1:       phase_threshold = '1;
            2:       phase_threshold = TIME_W'($urandom_range(3000000, 100000));
            3:       phase_threshold = TIME_W'(1);
            4:       phase_threshold = THRESH_RESET;
            default: phase_threshold = TIME_W'(750000);
         endcase
         write_threshold(phase_threshold);
         // receiver-heavy gaps first, then sender-heavy, then none
         if (ph < 2) begin
            send_idle_pct = 31;
            recv_idle_pct = 62;
         end else if (ph < 4) begin
            send_idle_pct = 62;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 4) hold_request = 1'b1;
         for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
            send_random(took);
         end
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.grants_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: ring_neighbor_arbiter_aging_unit.f
+incdir+rtl/core
rtl/core/rnaa_pkg.sv
rtl/core/rnaa_wait_stage.sv
rtl/core/rnaa_grant_stage.sv
rtl/core/rnaa_rsp_queue.sv
rtl/core/ring_neighbor_arbiter_aging_unit.sv
bench/tb_ring_neighbor_arbiter_aging_unit.sv
